FILE: rtl/spq_pkg.sv
// Shared types, default sizes and codes for the sorted priority queue.
package spq_pkg;

  // Default sizes of the queue.
  localparam int SPQ_DEPTH     = 16;
  localparam int SPQ_PRIO_BITS = 8;
  localparam int SPQ_TAG_BITS  = 16;

  // Command codes carried on the input tuser bit.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Result status codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_REMOVED  = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_op_t;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the queue: holds an entry and trades it with its neighbours.
module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIO_BITS = SPQ_PRIO_BITS,
  parameter int TAG_BITS  = SPQ_TAG_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_op_t             op,
  input  logic [PRIO_BITS-1:0] new_prio,
  input  logic [TAG_BITS-1:0]  new_tag,
  // Neighbour nearer the head.
  input  logic                 left_take,
  input  logic                 left_valid,
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]  left_tag,
  // Neighbour nearer the tail.
  input  logic                 right_valid,
  input  logic [PRIO_BITS-1:0] right_prio,
  input  logic [TAG_BITS-1:0]  right_tag,
  // This slot.
  output logic                 take,
  output logic                 valid,
  output logic [PRIO_BITS-1:0] prio,
  output logic [TAG_BITS-1:0]  tag
);

  logic                 valid_next;
  logic [PRIO_BITS-1:0] prio_next;
  logic [TAG_BITS-1:0]  tag_next;

  // The new entry belongs here or further towards the head when this slot is
  // empty or holds a strictly lower priority, which keeps equal priorities in
  // arrival order.
  assign take = !valid || (new_prio > prio);

  // Next contents: shift towards the tail or take the new entry on insert,
  // shift towards the head on remove, otherwise hold.
  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    tag_next   = tag;
    if (op.insert) begin
      if (left_take) begin
        valid_next = left_valid;
        prio_next  = left_prio;
        tag_next   = left_tag;
      end else if (take) begin
        valid_next = 1'b1;
        prio_next  = new_prio;
        tag_next   = new_tag;
      end
    end else if (op.remove) begin
      valid_next = right_valid;
      prio_next  = right_prio;
      tag_next   = right_tag;
    end
  end

  // The valid flag is control state; the entry itself needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    tag  <= tag_next;
  end

endmodule

FILE: rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a chain of slot cells and the result register.
//
//  channel  direction  tuser          tdata (lowest bit up)
//  s_*      in         command        priority_req, payload_tag
//  m_*      out        status         out_priority, out_tag, queue_count
//
// Every transfer in is served by the whole chain at once: all cells compare the new
// priority with their own in parallel and shift by one slot together.
// Its result stands on the master side in the cycle after the transfer.
// A new transfer is taken whenever the result register is empty or is
// being emptied in the same cycle; a stalled master side stalls the input.
// Reset empties every slot and the result register at once.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH     = SPQ_DEPTH,
  parameter int PRIO_BITS = SPQ_PRIO_BITS,
  parameter int TAG_BITS  = SPQ_TAG_BITS,
  localparam int CNT_BITS = $clog2(DEPTH + 1),
  localparam int IN_W     = ((PRIO_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int OUT_W    = ((PRIO_BITS + TAG_BITS + CNT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // priority_req, payload_tag
  input  logic             s_tuser,   // command
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_priority, out_tag, queue_count
  output logic [1:0]       m_tuser    // status
);

  logic [PRIO_BITS-1:0] in_prio;
  logic [TAG_BITS-1:0]  in_tag;
  logic                 xfer_in;
  logic                 is_remove;
  logic                 full;
  logic                 empty;
  cell_op_t             op;

  logic [CNT_BITS-1:0]  count;
  logic [CNT_BITS-1:0]  count_next;

  logic                 take   [DEPTH];
  logic                 valid  [DEPTH];
  logic [PRIO_BITS-1:0] prio_q [DEPTH];
  logic [TAG_BITS-1:0]  tag_q  [DEPTH];

  status_t              res_status;
  logic [PRIO_BITS-1:0] res_prio;
  logic [TAG_BITS-1:0]  res_tag;

  logic                 out_valid;
  status_t              out_status;
  logic [PRIO_BITS-1:0] out_prio;
  logic [TAG_BITS-1:0]  out_tag;
  logic [CNT_BITS-1:0]  out_count;

  // Input unpacking and the transfer condition.
  assign in_prio   = s_tdata[PRIO_BITS-1:0];
  assign in_tag    = s_tdata[PRIO_BITS+TAG_BITS-1:PRIO_BITS];
  assign s_tready  = !out_valid || m_tready;
  assign xfer_in   = s_tvalid && s_tready;
  assign is_remove = (s_tuser == CMD_REMOVE);
  assign full      = (count == CNT_BITS'(DEPTH));
  assign empty     = (count == '0);

  // Operation for the cells; a refused insert or an empty remove leaves them.
  assign op.insert = xfer_in && !is_remove && !full;
  assign op.remove = xfer_in && is_remove && !empty;

  // Chain of slot cells, head at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_take;
    logic                 l_valid;
    logic [PRIO_BITS-1:0] l_prio;
    logic [TAG_BITS-1:0]  l_tag;
    logic                 r_valid;
    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  r_tag;

    if (i == 0) begin : g_head
      assign l_take  = 1'b0;
      assign l_valid = 1'b0;
      assign l_prio  = '0;
      assign l_tag   = '0;
    end else begin : g_mid_l
      assign l_take  = take[i-1];
      assign l_valid = valid[i-1];
      assign l_prio  = prio_q[i-1];
      assign l_tag   = tag_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_prio  = '0;
      assign r_tag   = '0;
    end else begin : g_mid_r
      assign r_valid = valid[i+1];
      assign r_prio  = prio_q[i+1];
      assign r_tag   = tag_q[i+1];
    end

    spq_cell #(
      .PRIO_BITS (PRIO_BITS),
      .TAG_BITS  (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .new_prio    (in_prio),
      .new_tag     (in_tag),
      .left_take   (l_take),
      .left_valid  (l_valid),
      .left_prio   (l_prio),
      .left_tag    (l_tag),
      .right_valid (r_valid),
      .right_prio  (r_prio),
      .right_tag   (r_tag),
      .take        (take[i]),
      .valid       (valid[i]),
      .prio        (prio_q[i]),
      .tag         (tag_q[i])
    );
  end

  // Result of the item and the entry count after it.
  always_comb begin
    res_prio   = '0;
    res_tag    = '0;
    count_next = count;
    if (!is_remove) begin
      if (full) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_INSERTED;
        count_next = count + 1'b1;
      end
    end else if (empty) begin
      res_status = ST_EMPTY;
    end else begin
      res_status = ST_REMOVED;
      res_prio   = prio_q[0];
      res_tag    = tag_q[0];
      count_next = count - 1'b1;
    end
  end

  // Entry count and the valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (xfer_in) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      out_status <= res_status;
      out_prio   <= res_prio;
      out_tag    <= res_tag;
      out_count  <= count_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = OUT_W'({out_count, out_tag, out_prio});

endmodule

FILE: sim/sorted_priority_queue_core_tb.sv
// Self-checking testbench for the sorted priority queue core.
module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int DEPTH     = SPQ_DEPTH;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 32;
  localparam int MAX_CYCLES = 200000;
  localparam int PHASE_OPS = 235;

  // One queue operation as presented on the slave side.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  prio;
    logic [15:0] tag;
  } queue_op_t;

  // One result as seen on the master side.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [15:0] tag;
    logic [4:0]  count;
  } queue_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = CMD_INSERT;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  // Operations still to be sent, and results still to arrive.
  queue_op_t     op_backlog[$];
  queue_result_t awaited[$];

  // Shadow copy of the queue contents, head at index 0.
  logic [7:0]  shadow_prio[DEPTH];
  logic [15:0] shadow_tag[DEPTH];
  int          shadow_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int max_held = 0;
  longint cycles = 0;

  sorted_priority_queue_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // priority_req, payload_tag
    .s_tuser  (s_tuser),   // command
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // out_priority, out_tag, queue_count
    .m_tuser  (m_tuser)    // status
  );

  // Clock generation.
  always #10 clk = ~clk;

  // Applies one operation to the shadow queue and returns the result it yields.
  function automatic queue_result_t apply_queue_op(input queue_op_t op);
    queue_result_t r;
    int pos;
    r.status = ST_INSERTED;
    r.prio   = '0;
    r.tag    = '0;
    if (op.cmd == CMD_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Equal priorities stay behind the older entries.
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= op.prio) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_prio[i] = shadow_prio[i-1];
          shadow_tag[i]  = shadow_tag[i-1];
        end
        shadow_prio[pos] = op.prio;
        shadow_tag[pos]  = op.tag;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_REMOVED;
      r.prio   = shadow_prio[0];
      r.tag    = shadow_tag[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_prio[i-1] = shadow_prio[i];
        shadow_tag[i-1]  = shadow_tag[i];
      end
      shadow_count--;
    end
    r.count = shadow_count[4:0];
    if (shadow_count > max_held) max_held = shadow_count;
    return r;
  endfunction

  // Driver: presents the backlog on the slave side and predicts each accepted transfer.
  always @(posedge clk) begin : drive
    queue_op_t nxt;
    queue_op_t held_op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        held_op.cmd  = s_tuser;
        held_op.prio = s_tdata[7:0];
        held_op.tag  = s_tdata[23:8];
        awaited.push_back(apply_queue_op(held_op));
      end
      if (!s_tvalid || s_tready) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = op_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.cmd;
          s_tdata  <= {nxt.tag, nxt.prio};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin : observe
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.prio   = m_tdata[7:0];
        got.tag    = m_tdata[23:8];
        got.count  = m_tdata[28:24];
        results_seen++;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result status=%0d prio=%0d tag=%h count=%0d",
                     got.status, got.prio, got.tag, got.count);
        end else begin
          want = awaited.pop_front();
          status_seen[want.status]++;
          if (got.status !== want.status || got.prio !== want.prio ||
              got.tag !== want.tag || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d expected status=%0d prio=%0d tag=%h count=%0d,",
                       results_seen, want.status, want.prio, want.tag, want.count);
              $display("       got status=%0d prio=%0d tag=%h count=%0d",
                       got.status, got.prio, got.tag, got.count);
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, awaited.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic queue_op_t make_op(input logic cmd, input logic [7:0] prio,
                                        input logic [15:0] tag);
    queue_op_t op;
    op.cmd  = cmd;
    op.prio = prio;
    op.tag  = tag;
    return op;
  endfunction

  // Random operation; narrow priority ranges give plenty of equal-priority ties.
  function automatic queue_op_t random_op(input int insert_pct);
    logic [7:0] prio;
    case ($urandom_range(3))
      0: prio = $urandom_range(1) ? 8'hFF : 8'h00;
      1: prio = 8'($urandom_range(7));
      default: prio = 8'($urandom);
    endcase
    return make_op(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                   prio, 16'($urandom));
  endfunction

  // Blocks until every queued operation has been sent and answered. The check is made
  // on the falling edge, once the driver and monitor updates of the rising edge settle.
  task automatic wait_drained();
    while (op_backlog.size() != 0 || s_tvalid || awaited.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int added;
    int burst;
    int insert_pct;
    int idle_plan[3][2];
    idle_plan = '{'{25, 80}, '{80, 25}, '{0, 0}};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty remove, extremes, a tie run, filling up and a refused insert.
    op_backlog.push_back(make_op(CMD_REMOVE, 8'hFF, 16'hFFFF));
    op_backlog.push_back(make_op(CMD_INSERT, 8'hFF, 16'hFFFF));
    op_backlog.push_back(make_op(CMD_INSERT, 8'h00, 16'h0000));
    op_backlog.push_back(make_op(CMD_INSERT, 8'h80, 16'h0001));
    op_backlog.push_back(make_op(CMD_INSERT, 8'h80, 16'h0002));
    op_backlog.push_back(make_op(CMD_INSERT, 8'h80, 16'h0003));
    op_backlog.push_back(make_op(CMD_REMOVE, 8'h00, 16'h0000));
    op_backlog.push_back(make_op(CMD_REMOVE, 8'h00, 16'h0000));
    for (int i = 0; i < 13; i++)
      op_backlog.push_back(make_op(CMD_INSERT, 8'(i * 37), 16'(16'hA500 + i)));
    op_backlog.push_back(make_op(CMD_INSERT, 8'hFF, 16'h5A5A));
    op_backlog.push_back(make_op(CMD_INSERT, 8'h00, 16'h1234));
    op_backlog.push_back(make_op(CMD_REMOVE, 8'h55, 16'hAAAA));
    op_backlog.push_back(make_op(CMD_REMOVE, 8'hAA, 16'h5555));
    wait_drained();

    // Random phases with different idle and stall mixes; each ends fully drained.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = idle_plan[ph][0];
      recv_stall_pct = idle_plan[ph][1];
      added = 0;
      while (added < PHASE_OPS) begin
        burst = $urandom_range(10, 40);
        case ($urandom_range(2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
        for (int i = 0; i < burst; i++) op_backlog.push_back(random_op(insert_pct));
        added += burst;
      end
      wait_drained();
    end

    repeat (5) @(posedge clk);
    $display("Checked %0d results: %0d inserted, %0d refused full, %0d empty, %0d removed",
             results_seen, status_seen[ST_INSERTED], status_seen[ST_FULL],
             status_seen[ST_EMPTY], status_seen[ST_REMOVED]);
    $display("Peak occupancy %0d of %0d over three idle/stall mixes, %0d mismatches",
             max_held, DEPTH, mismatches);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
sim/sorted_priority_queue_core_tb.sv
